// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, a, b, msg)
`define ASSERT_NEXT(lbl, clk, rstn, a, b, msg)

`endif

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// ---------------------------------------------------------------------------
// ffha_pkg
// types, constants and microprogram of the first-fit heap allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	localparam int HDR_W = 16;
	localparam int LEN_W = 15;
	localparam int REQ_W = 16;
	localparam int OFF_W = 11;
	localparam int SUM_W = 17;

	localparam logic [HDR_W-1:0] LEN_MASK  = 16'h7FFF;
	localparam logic [HDR_W-1:0] ALLOC_BIT = 16'h8000;

	typedef enum logic [4:0] {
		U_IDLE, U_ACHK, U_RD, U_HDR, U_ALC, U_FIT, U_MNX, U_MHD, U_MADD, U_MFIT,
		U_MEND, U_SKIP, U_SPLIT, U_REM, U_WHOLE, U_OK, U_FAIL, U_F1, U_F2, U_FOK
	} upc_t;

	typedef enum logic [1:0] {W_NONE, W_IN, W_OUT} wait_t;
	typedef enum logic [1:0] {RD_NONE, RD_POS, RD_NEXT, RD_FREE} rd_t;
	typedef enum logic [2:0] {
		WR_NONE, WR_MERGE, WR_PART, WR_WHOLE, WR_REM, WR_CLR
	} wr_t;
	typedef enum logic [2:0] {
		OP_NONE, OP_LOAD_IN, OP_LD_HDR, OP_LD_NHDR, OP_MADD, OP_SKIP
	} op_t;
	typedef enum logic [3:0] {
		C_NEVER, C_ALWAYS, C_MODE_FREE, C_REQ_BIG, C_POS_END, C_HDR_BAD,
		C_HDR_ALLOC, C_FITS, C_NOFIT, C_NEXT_END, C_MRG_STOP, C_REM_SMALL,
		C_FREE_BAD
	} cond_t;
	typedef enum logic [1:0] {RES_NONE, RES_ALLOC, RES_FREE, RES_FAIL} res_t;

	typedef struct packed {
		wait_t wt;
		rd_t   rd;
		wr_t   wr;
		op_t   op;
		cond_t cond;
		upc_t  jmp;
		res_t  res;
	} ctrl_t;

	function automatic ctrl_t mk(wait_t wt, rd_t rd, wr_t wr, op_t op, cond_t cond,
			upc_t jmp, res_t res);
		ctrl_t c;
		c.wt = wt;
		c.rd = rd;
		c.wr = wr;
		c.op = op;
		c.cond = cond;
		c.jmp = jmp;
		c.res = res;
		return c;
	endfunction

	// control store: one word per step, jump when the condition holds, else fall through
	function automatic ctrl_t ucode(upc_t a);
		ctrl_t c;
		unique case (a)
			U_IDLE:  c = mk(W_IN,   RD_NONE, WR_NONE,  OP_LOAD_IN, C_MODE_FREE, U_F1,   RES_NONE);
			U_ACHK:  c = mk(W_NONE, RD_NONE, WR_NONE,  OP_NONE,    C_REQ_BIG,   U_FAIL, RES_NONE);
			U_RD:    c = mk(W_NONE, RD_POS,  WR_NONE,  OP_NONE,    C_POS_END,   U_FAIL, RES_NONE);
			U_HDR:   c = mk(W_NONE, RD_NONE, WR_NONE,  OP_LD_HDR,  C_HDR_BAD,   U_FAIL, RES_NONE);
			U_ALC:   c = mk(W_NONE, RD_NONE, WR_NONE,  OP_NONE,    C_HDR_ALLOC, U_SKIP, RES_NONE);
			U_FIT:   c = mk(W_NONE, RD_NONE, WR_NONE,  OP_NONE,    C_FITS,      U_SPLIT, RES_NONE);
			U_MNX:   c = mk(W_NONE, RD_NEXT, WR_NONE,  OP_NONE,    C_NEXT_END,  U_MEND, RES_NONE);
			U_MHD:   c = mk(W_NONE, RD_NONE, WR_NONE,  OP_LD_NHDR, C_MRG_STOP,  U_MEND, RES_NONE);
			U_MADD:  c = mk(W_NONE, RD_NONE, WR_NONE,  OP_MADD,    C_NEVER,     U_IDLE, RES_NONE);
			U_MFIT:  c = mk(W_NONE, RD_NONE, WR_NONE,  OP_NONE,    C_NOFIT,     U_MNX,  RES_NONE);
			U_MEND:  c = mk(W_NONE, RD_NONE, WR_MERGE, OP_NONE,    C_FITS,      U_SPLIT, RES_NONE);
			U_SKIP:  c = mk(W_NONE, RD_NONE, WR_NONE,  OP_SKIP,    C_ALWAYS,    U_RD,   RES_NONE);
			U_SPLIT: c = mk(W_NONE, RD_NONE, WR_PART,  OP_NONE,    C_REM_SMALL, U_WHOLE, RES_NONE);
			U_REM:   c = mk(W_NONE, RD_NONE, WR_REM,   OP_NONE,    C_ALWAYS,    U_OK,   RES_NONE);
			U_WHOLE: c = mk(W_NONE, RD_NONE, WR_WHOLE, OP_NONE,    C_NEVER,     U_IDLE, RES_NONE);
			U_OK:    c = mk(W_OUT,  RD_NONE, WR_NONE,  OP_NONE,    C_ALWAYS,    U_IDLE, RES_ALLOC);
			U_FAIL:  c = mk(W_OUT,  RD_NONE, WR_NONE,  OP_NONE,    C_ALWAYS,    U_IDLE, RES_FAIL);
			U_F1:    c = mk(W_NONE, RD_FREE, WR_NONE,  OP_NONE,    C_FREE_BAD,  U_FAIL, RES_NONE);
			U_F2:    c = mk(W_NONE, RD_NONE, WR_CLR,   OP_NONE,    C_NEVER,     U_IDLE, RES_NONE);
			U_FOK:   c = mk(W_OUT,  RD_NONE, WR_NONE,  OP_NONE,    C_ALWAYS,    U_IDLE, RES_FREE);
			default: c = mk(W_NONE, RD_NONE, WR_NONE,  OP_NONE,    C_ALWAYS,    U_IDLE, RES_NONE);
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ffha_ram.sv =====
// ---------------------------------------------------------------------------
// ffha_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// allocate: walks the block headers from offset 0, skipping allocated blocks; a free block
// too small is merged with the free blocks after it, and the first block that fits is
// split or taken whole; free: clears the allocated bit; oversized or out-of-range items fail.
// one item at a time, one header read per step; a new item is accepted while a result waits.
// reset: asynchronous, clears sequencer and output valid; the heap restarts as one free
// block through a flag on entry 0, so there is no clearing pass.
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// microcoded first-fit allocator over an implicit list of block headers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES = 2048
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             mode,
	input  wire logic [REQ_W-1:0] request_size,
	input  wire logic [OFF_W-1:0] free_offset,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [OFF_W-1:0] payload_offset,
	output logic                  success
);

	localparam int ADDR_W = $clog2(HEAP_BYTES);
	localparam logic [SUM_W-1:0] HEAP_SUM = SUM_W'(HEAP_BYTES);
	localparam logic [HDR_W-1:0] HEAP_HDR = HDR_W'(HEAP_BYTES);

	upc_t upc_q, upc_d;
	ctrl_t cw;
	logic adv, cond;

	logic [SUM_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [REQ_W-1:0] req_q;
	logic [HDR_W-1:0] hdr_q;
	logic [OFF_W-1:0] off_q;
	logic merged_q;
	logic hdr0_valid_q;
	logic rd0_inv_q;

	logic [HDR_W-1:0] ram_rdata, hdr_w;
	logic ram_we, ram_re;
	logic [SUM_W-1:0] waddr_full, raddr_full;
	logic [HDR_W-1:0] wdata;

	logic [SUM_W-1:0] need, next_pos, split_pos, rem, free_hdr, len_ext;
	logic [HDR_W-1:0] merge_sum;
	logic fits;

	assign cw = ucode(upc_q);
	assign in_stall = (upc_q != U_IDLE);

	always_comb begin
		unique case (cw.wt)
			W_IN:    adv = in_valid;
			W_OUT:   adv = !out_valid || !out_stall;
			default: adv = 1'b1;
		endcase
	end

	// entry 0 reads as the full heap until it is first written
	assign hdr_w = rd0_inv_q ? HEAP_HDR : ram_rdata;

	assign len_ext   = SUM_W'(len_q);
	assign need      = SUM_W'(req_q) + SUM_W'(2);
	assign fits      = (need <= len_ext);
	assign next_pos  = pos_q + len_ext;
	assign split_pos = pos_q + need;
	assign rem       = len_ext - need;
	assign free_hdr  = SUM_W'(off_q) - SUM_W'(2);
	assign merge_sum = HDR_W'(len_q) + (hdr_w & LEN_MASK);

	always_comb begin
		case (cw.cond)
			C_ALWAYS:    cond = 1'b1;
			C_MODE_FREE: cond = mode;
			C_REQ_BIG:   cond = (SUM_W'(req_q) > HEAP_SUM);
			C_POS_END:   cond = (pos_q >= HEAP_SUM);
			C_HDR_BAD:   cond = (hdr_w == '0) || ((hdr_w & LEN_MASK) < HDR_W'(2));
			C_HDR_ALLOC: cond = hdr_q[HDR_W-1];
			C_FITS:      cond = fits;
			C_NOFIT:     cond = !fits;
			C_NEXT_END:  cond = (next_pos >= HEAP_SUM);
			C_MRG_STOP:  cond = (hdr_w == '0) || hdr_w[HDR_W-1] || (merge_sum > LEN_MASK);
			C_REM_SMALL: cond = (rem < SUM_W'(2));
			C_FREE_BAD:  cond = (off_q < OFF_W'(2)) || (free_hdr >= HEAP_SUM);
			default:     cond = 1'b0;
		endcase
	end

	always_comb begin
		if (!adv) begin
			upc_d = upc_q;
		end else if (cond) begin
			upc_d = cw.jmp;
		end else begin
			upc_d = upc_t'(5'(upc_q) + 5'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	// read and write port decode
	always_comb begin
		ram_re = adv;
		unique case (cw.rd)
			RD_POS:  raddr_full = pos_q;
			RD_NEXT: raddr_full = next_pos;
			RD_FREE: raddr_full = free_hdr;
			default: begin
				raddr_full = pos_q;
				ram_re = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_we = adv;
		waddr_full = pos_q;
		wdata = HDR_W'(len_q);
		unique case (cw.wr)
			WR_MERGE: ram_we = adv && merged_q;
			WR_PART:  wdata = need[HDR_W-1:0] | ALLOC_BIT;
			WR_WHOLE: wdata = HDR_W'(len_q) | ALLOC_BIT;
			WR_REM: begin
				ram_we = adv && (split_pos < HEAP_SUM);
				waddr_full = split_pos;
				wdata = rem[HDR_W-1:0];
			end
			WR_CLR: begin
				waddr_full = free_hdr;
				wdata = hdr_w & LEN_MASK;
			end
			default: ram_we = 1'b0;
		endcase
	end

	ffha_ram #(
		.WIDTH(HDR_W),
		.DEPTH(HEAP_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_full[ADDR_W-1:0]),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(raddr_full[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_valid_q <= 1'b0;
			rd0_inv_q <= 1'b0;
		end else begin
			if (ram_we && (waddr_full == '0)) begin
				hdr0_valid_q <= 1'b1;
			end
			if (ram_re) begin
				rd0_inv_q <= (raddr_full == '0) && !hdr0_valid_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			case (cw.op)
				OP_LOAD_IN: begin
					req_q <= request_size;
					off_q <= free_offset;
					pos_q <= '0;
				end
				OP_LD_HDR: begin
					hdr_q <= hdr_w;
					len_q <= hdr_w[LEN_W-1:0];
					merged_q <= 1'b0;
				end
				OP_LD_NHDR: hdr_q <= hdr_w;
				OP_MADD: begin
					len_q <= len_q + hdr_q[LEN_W-1:0];
					merged_q <= 1'b1;
				end
				OP_SKIP: pos_q <= next_pos;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv && (cw.res != RES_NONE)) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (cw.res)
				RES_ALLOC: begin
					payload_offset <= split_pos[OFF_W-1:0] - need[OFF_W-1:0]
						+ OFF_W'(2);
					success <= 1'b1;
				end
				RES_FREE: begin
					payload_offset <= '0;
					success <= 1'b1;
				end
				RES_FAIL: begin
					payload_offset <= '0;
					success <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	`ASSERT_IMPLY(a_wr_in_heap, clk, arst_n, ram_we, waddr_full < HEAP_SUM, "header write beyond heap")
	`ASSERT_IMPLY(a_split_fits, clk, arst_n, upc_q == U_SPLIT, fits, "split of a block that is too small")
	`ASSERT_IMPLY(a_out_source, clk, arst_n, $rose(out_valid), $past(upc_q) == U_OK || $past(upc_q) == U_FAIL || $past(upc_q) == U_FOK, "result without a result step")
	`ASSERT_NEXT(a_leave_idle, clk, arst_n, in_valid && !in_stall, upc_q != U_IDLE, "accepted item left sequencer idle")

endmodule

`default_nettype wire
